@@ src/jfif_color_space_converter_assert.svh @@
// Assertion macros used by the color space converter RTL.
`ifndef JFIF_COLOR_SPACE_CONVERTER_ASSERT_SVH
`define JFIF_COLOR_SPACE_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define JCSC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("jfif_color_space_converter: assertion failed");
// Checks that an antecedent is followed by a consequent in the next cycle.
`define JCSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jfif_color_space_converter: assertion failed");
`else
`define JCSC_ASSERT(label, prop)
`define JCSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/jcsc_pkg.sv @@
// Types, fixed-point widths and coefficient tables of the JFIF color space converter.
package jcsc_pkg;

   typedef enum logic {
      MODE_RGB_TO_YCC = 1'b0,
      MODE_YCC_TO_RGB = 1'b1
   } mode_type;

   localparam int CoefFracBits = 16;

   localparam int CompW  = 9;
   localparam int OpW    = CompW + 1;
   localparam int CoefW  = CoefFracBits + 3;
   localparam int ProdW  = OpW + CoefW;
   localparam int SumW   = ProdW + 2;
   localparam int QuotW  = SumW - CoefFracBits;
   localparam int BiasW  = QuotW + 1;
   localparam int DataW  = ((3 * CompW + 7) / 8) * 8;

   localparam int LevelShift = 128;
   localparam int FwdLo      = -256;
   localparam int InvLo      = 0;
   localparam int CompHi     = 255;

   localparam longint Scale = longint'(1) << CoefFracBits;
   localparam longint Half  = longint'(1) << (CoefFracBits - 1);

   typedef logic signed [CompW-1:0] comp_type;
   typedef logic signed [OpW-1:0]   op_type;
   typedef logic signed [CoefW-1:0] coef_type;
   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic signed [SumW-1:0]  sum_type;

   // Coefficient magnitudes rounded to nearest, halves up; sign applied after.
   localparam longint KYR  = (299 * Scale + 500) / 1000;
   localparam longint KYG  = (587 * Scale + 500) / 1000;
   localparam longint KYB  = (114 * Scale + 500) / 1000;
   localparam longint KCbR = (1687 * Scale + 5000) / 10000;
   localparam longint KCbG = (3313 * Scale + 5000) / 10000;
   localparam longint KHalf = (5 * Scale + 5) / 10;
   localparam longint KCrG = (4187 * Scale + 5000) / 10000;
   localparam longint KCrB = (813 * Scale + 5000) / 10000;
   localparam longint KOne = Scale;
   localparam longint KRCr = (1402 * Scale + 500) / 1000;
   localparam longint KGCb = (34414 * Scale + 50000) / 100000;
   localparam longint KGCr = (71414 * Scale + 50000) / 100000;
   localparam longint KBCb = (1772 * Scale + 500) / 1000;

   localparam coef_type FwdCoef [3][3] = '{
      '{ coef_type'(KYR),   coef_type'(KYG),   coef_type'(KYB)   },
      '{ coef_type'(-KCbR), coef_type'(-KCbG), coef_type'(KHalf) },
      '{ coef_type'(KHalf), coef_type'(-KCrG), coef_type'(-KCrB) }
   };

   localparam coef_type InvCoef [3][3] = '{
      '{ coef_type'(KOne), coef_type'(0),     coef_type'(KRCr)  },
      '{ coef_type'(KOne), coef_type'(-KGCb), coef_type'(-KGCr) },
      '{ coef_type'(KOne), coef_type'(KBCb),  coef_type'(0)     }
   };

endpackage

@@ src/jfif_color_space_converter.sv @@
// Top level of the JFIF color space converter: a four-stage matrix multiply pipeline.
//
// Converts one pixel per request between RGB and JFIF level-shifted YCbCr.
// The request's tuser bit selects the direction: RGB to YCbCr subtracts 128
// from each component and applies the JFIF matrix without clamping (only
// saturation to the 9-bit signed range); YCbCr to RGB applies the inverse
// matrix, adds 128 and clamps to 0..255. Coefficients carry 16 fraction bits
// and each output is rounded by adding one half and truncating toward zero,
// so results can differ by one from a floating-point conversion near a
// rounding boundary. The block accepts one request every clock cycle
// while the request side is not stalled. One stage registers the
// operands, one forms the nine products, one adds them with the rounding
// half, and one rounds, biases and clamps into the output register. Each
// stage has its own valid bit and advances whenever the stage after it can
// take its contents, so back pressure on the result side fills empty stages
// before it stalls the request side. There is no state between pixels;
// reset only clears the valid bits.
module jfif_color_space_converter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Bits from low to high: comp_a [8:0], comp_b [17:9], comp_c [26:18], zero fill.
   input  logic [jcsc_pkg::DataW-1:0] req_tdata,
   // Bit 0: mode (0 = RGB to YCbCr, 1 = YCbCr to RGB).
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Bits from low to high: out_a [8:0], out_b [17:9], out_c [26:18], zero fill.
   output logic [jcsc_pkg::DataW-1:0] rsp_tdata
);
   import jcsc_pkg::*;

`include "jfif_color_space_converter_assert.svh"

   // Valid bits, one per stage, and the per-stage advance conditions.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: signed operands and direction.
   mode_type s1_mode_ff;
   op_type   s1_op_ff [3];
   op_type   s1_op_in [3];
   comp_type req_comp [3];

   // Stage 2: the nine products.
   mode_type s2_mode_ff;
   prod_type s2_prod_ff [3][3];
   prod_type s2_prod_in [3][3];

   // Stage 3: row sums including the rounding half.
   mode_type s3_mode_ff;
   sum_type  s3_sum_ff [3];
   sum_type  s3_sum_in [3];

   // Stage 4: output register.
   logic [3*CompW-1:0] rsp_ff;
   logic [3*CompW-1:0] rsp_in;

   // A stage takes new contents when it is empty or its contents move on.
   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Forward conversion works on level-shifted components; the inverse takes them as they are.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         req_comp[j] = comp_type'(req_tdata[j*CompW +: CompW]);
         if (mode_type'(req_tuser) == MODE_RGB_TO_YCC) begin
            s1_op_in[j] = op_type'(req_comp[j]) - op_type'(LevelShift);
         end else begin
            s1_op_in[j] = op_type'(req_comp[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         s1_mode_ff <= mode_type'(req_tuser);
         for (int j = 0; j < 3; j++) begin
            s1_op_ff[j] <= s1_op_in[j];
         end
      end
   end

   // Each product multiplies an operand by a constant picked by the direction.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (s1_mode_ff == MODE_YCC_TO_RGB) begin
               s2_prod_in[i][j] = prod_type'(InvCoef[i][j]) * prod_type'(s1_op_ff[j]);
            end else begin
               s2_prod_in[i][j] = prod_type'(FwdCoef[i][j]) * prod_type'(s1_op_ff[j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_mode_ff <= s1_mode_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sum_in[i] = sum_type'(s2_prod_ff[i][0]) + sum_type'(s2_prod_ff[i][1])
                      + sum_type'(s2_prod_ff[i][2]) + sum_type'(Half);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_mode_ff <= s2_mode_ff;
         s3_sum_ff  <= s3_sum_in;
      end
   end

   // Truncation toward zero: a negative sum gets one less than the divisor added first.
   always_comb begin
      sum_type                  adj;
      logic signed [QuotW-1:0]  quot;
      logic signed [BiasW-1:0]  biased;
      logic signed [BiasW-1:0]  lo;
      logic signed [BiasW-1:0]  hi;
      rsp_in = '0;
      for (int i = 0; i < 3; i++) begin
         adj  = s3_sum_ff[i] + (s3_sum_ff[i][SumW-1] ? sum_type'(Scale - 1) : sum_type'(0));
         quot = adj[SumW-1:CoefFracBits];
         hi   = BiasW'(CompHi);
         if (s3_mode_ff == MODE_YCC_TO_RGB) begin
            biased = BiasW'(quot) + BiasW'(LevelShift);
            lo     = BiasW'(InvLo);
         end else begin
            biased = BiasW'(quot);
            lo     = BiasW'(FwdLo);
         end
         if (biased < lo) begin
            biased = lo;
         end else if (biased > hi) begin
            biased = hi;
         end
         rsp_in[i*CompW +: CompW] = biased[CompW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(DataW - 3*CompW){1'b0}}, rsp_ff};

   // A stalled sum stage keeps its item unchanged.
   `JCSC_ASSERT_NEXT(a_sum_stage_holds, v3_ff && !rdy3, v3_ff && $stable(s3_sum_ff[0]) && $stable(s3_sum_ff[1]) && $stable(s3_sum_ff[2]))
   // An empty first stage always takes a request.
   `JCSC_ASSERT(a_empty_accepts, !v1_ff |-> req_tready)
   // Inverse results land inside 0..255.
   `JCSC_ASSERT_NEXT(a_inverse_clamped, v3_ff && rdy4 && s3_mode_ff == MODE_YCC_TO_RGB, !rsp_tdata[CompW-1] && !rsp_tdata[2*CompW-1] && !rsp_tdata[3*CompW-1])
   // A result only appears when the sum stage held an item the cycle before.
   `JCSC_ASSERT(a_result_has_source, $rose(rsp_tvalid) |-> $past(v3_ff))

endmodule
